>>> hdl/qfk_pkg.sv
`timescale 1ns / 1ps

package qfk_pkg;

  // Queue geometry
  localparam int DEPTH   = 64;
  localparam int PTR_W   = $clog2(DEPTH);
  localparam int CNT_W   = $clog2(DEPTH + 1);

  // Field widths
  localparam int ID_W    = 37;
  localparam int PAY_W   = 32;
  localparam int OCC_W   = 7;
  localparam int ACT_W   = 2;
  localparam int ST_W    = 2;
  localparam int ENTRY_W = ID_W + PAY_W;

  // Stream data widths, padded to whole bytes
  localparam int IN_DATA_W  = ((ID_W + PAY_W + 7) / 8) * 8;
  localparam int OUT_DATA_W = ((ID_W + PAY_W + OCC_W + 7) / 8) * 8;

  // Action codes
  localparam logic [ACT_W-1:0] ACT_PUSH   = 2'd0;
  localparam logic [ACT_W-1:0] ACT_POP    = 2'd1;
  localparam logic [ACT_W-1:0] ACT_CANCEL = 2'd2;

  // Status codes
  localparam logic [ST_W-1:0] ST_OK       = 2'd0;
  localparam logic [ST_W-1:0] ST_FULL     = 2'd1;
  localparam logic [ST_W-1:0] ST_EMPTY    = 2'd2;
  localparam logic [ST_W-1:0] ST_NOTFOUND = 2'd3;

  typedef logic [PTR_W-1:0] ptr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic            capture;     // latch the accepted transaction
    logic            push;        // write at tail, count up
    logic            rd_head;     // read head slot, restart the walk
    logic            rd_next;     // read the next slot of the walk
    logic            pop_take;    // take head data, advance head, count down
    logic            shift_wr;    // move read entry one place toward head
    logic            drop_one;    // count down after a removal by key
    logic            set_res;     // load result status
    logic [ST_W-1:0] res_status;
    logic            load_out;    // move the result into the output register
  } qfk_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic [ACT_W-1:0] act;
    logic             full;
    logic             empty;
    logic             match;      // entry under the walk holds the key
    logic             last;       // entry under the walk is the tail
    logic             out_free;   // output register can take a result
  } qfk_sts_t;

  function automatic ptr_t ptr_inc(input ptr_t p);
    if (p == PTR_W'(DEPTH - 1)) begin
      return '0;
    end
    return p + PTR_W'(1);
  endfunction

  function automatic ptr_t ptr_add(input ptr_t base, input cnt_t off);
    logic [PTR_W:0] sum;
    sum = {1'b0, base} + (PTR_W + 1)'(off);
    if (sum >= (PTR_W + 1)'(DEPTH)) begin
      sum = sum - (PTR_W + 1)'(DEPTH);
    end
    return sum[PTR_W-1:0];
  endfunction

endpackage

>>> hdl/qfk_ctrl.sv
`timescale 1ns / 1ps

module qfk_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  qfk_pkg::qfk_sts_t sts,
  output qfk_pkg::qfk_cmd_t cmd
);
  import qfk_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_DISPATCH = 6'b000010,
    S_POPWAIT  = 6'b000100,
    S_SCAN     = 6'b001000,
    S_SHIFT    = 6'b010000,
    S_RESULT   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_ready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (sts.act)
          ACT_PUSH: begin
            cmd.set_res = 1'b1;
            if (sts.full) begin
              cmd.res_status = ST_FULL;
            end else begin
              cmd.push       = 1'b1;
              cmd.res_status = ST_OK;
            end
            state_nxt = S_RESULT;
          end
          ACT_POP: begin
            if (sts.empty) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_EMPTY;
              state_nxt      = S_RESULT;
            end else begin
              cmd.rd_head = 1'b1;
              state_nxt   = S_POPWAIT;
            end
          end
          ACT_CANCEL: begin
            if (sts.empty) begin
              cmd.set_res    = 1'b1;
              cmd.res_status = ST_NOTFOUND;
              state_nxt      = S_RESULT;
            end else begin
              cmd.rd_head = 1'b1;
              state_nxt   = S_SCAN;
            end
          end
          default: begin
            cmd.set_res    = 1'b1;
            cmd.res_status = ST_OK;
            state_nxt      = S_RESULT;
          end
        endcase
      end
      S_POPWAIT: begin
        cmd.pop_take   = 1'b1;
        cmd.set_res    = 1'b1;
        cmd.res_status = ST_OK;
        state_nxt      = S_RESULT;
      end
      S_SCAN: begin
        if (sts.last) begin
          cmd.set_res = 1'b1;
          if (sts.match) begin
            cmd.drop_one   = 1'b1;
            cmd.res_status = ST_OK;
          end else begin
            cmd.res_status = ST_NOTFOUND;
          end
          state_nxt = S_RESULT;
        end else begin
          cmd.rd_next = 1'b1;
          if (sts.match) begin
            state_nxt = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        cmd.shift_wr = 1'b1;
        if (sts.last) begin
          cmd.drop_one   = 1'b1;
          cmd.set_res    = 1'b1;
          cmd.res_status = ST_OK;
          state_nxt      = S_RESULT;
        end else begin
          cmd.rd_next = 1'b1;
        end
      end
      S_RESULT: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

>>> hdl/qfk_dpath.sv
`timescale 1ns / 1ps

module qfk_dpath (
  input  logic                       clk,
  input  logic                       rst_n,
  input  qfk_pkg::qfk_cmd_t          cmd,
  output qfk_pkg::qfk_sts_t          sts,
  input  logic [qfk_pkg::ACT_W-1:0]  in_act,
  input  logic [qfk_pkg::ID_W-1:0]   in_key,
  input  logic [qfk_pkg::PAY_W-1:0]  in_pay,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [qfk_pkg::ST_W-1:0]   out_status,
  output logic [qfk_pkg::ID_W-1:0]   out_id,
  output logic [qfk_pkg::PAY_W-1:0]  out_pay,
  output logic [qfk_pkg::OCC_W-1:0]  out_occ
);
  import qfk_pkg::*;

  logic [ENTRY_W-1:0] mem [DEPTH];
  logic [ENTRY_W-1:0] rdata_r;

  logic [ACT_W-1:0]   act_r;
  logic [ID_W-1:0]    key_r;
  logic [PAY_W-1:0]   pay_r;

  ptr_t head_r, head_nxt;
  cnt_t count_r, count_nxt;
  cnt_t idx_r;
  ptr_t ptr_r, prev_ptr_r;

  logic [ST_W-1:0]    res_status_r;
  logic [ID_W-1:0]    res_id_r;
  logic [PAY_W-1:0]   res_pay_r;

  logic               out_valid_r;
  logic [ST_W-1:0]    out_status_r;
  logic [ID_W-1:0]    out_id_r;
  logic [PAY_W-1:0]   out_pay_r;
  logic [OCC_W-1:0]   out_occ_r;

  logic               we;
  ptr_t               waddr, raddr;
  logic [ENTRY_W-1:0] wdata;
  logic               re;

  // Memory port selection
  always_comb begin
    we    = cmd.push | cmd.shift_wr;
    waddr = cmd.push ? ptr_add(head_r, count_r) : prev_ptr_r;
    wdata = cmd.push ? {pay_r, key_r} : rdata_r;
    re    = cmd.rd_head | cmd.rd_next;
    raddr = cmd.rd_head ? head_r : ptr_inc(ptr_r);
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  // Transaction capture and walk pointers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      act_r <= in_act;
      key_r <= in_key;
      pay_r <= in_pay;
    end
    if (cmd.rd_head) begin
      ptr_r <= head_r;
      idx_r <= '0;
    end else if (cmd.rd_next) begin
      prev_ptr_r <= ptr_r;
      ptr_r      <= ptr_inc(ptr_r);
      idx_r      <= idx_r + CNT_W'(1);
    end
  end

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.push) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (cmd.pop_take) begin
      head_nxt  = ptr_inc(head_r);
      count_nxt = count_r - CNT_W'(1);
    end else if (cmd.drop_one) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      count_r <= '0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
    end
  end

  // Result hold
  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      res_status_r <= cmd.res_status;
    end
    if (cmd.pop_take) begin
      res_id_r  <= rdata_r[ID_W-1:0];
      res_pay_r <= rdata_r[ENTRY_W-1:ID_W];
    end else if (cmd.set_res) begin
      res_id_r  <= '0;
      res_pay_r <= '0;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_status_r <= res_status_r;
      out_id_r     <= res_id_r;
      out_pay_r    <= res_pay_r;
      out_occ_r    <= OCC_W'(count_r);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_status = out_status_r;
  assign out_id     = out_id_r;
  assign out_pay    = out_pay_r;
  assign out_occ    = out_occ_r;

  always_comb begin
    sts.act      = act_r;
    sts.full     = (count_r == CNT_W'(DEPTH));
    sts.empty    = (count_r == '0);
    sts.match    = (rdata_r[ID_W-1:0] == key_r);
    sts.last     = ((idx_r + CNT_W'(1)) == count_r);
    sts.out_free = !out_valid_r || out_ready;
  end

endmodule

>>> hdl/fifo_queue_with_cancel_by_key.sv
`timescale 1ns / 1ps

// Bounded FIFO of keyed entries with removal by key.
// Input stream: in_tuser carries the action (push, pop, cancel by key, or a
// no-op code); in_tdata carries the key and the payload. Output stream: one
// result transaction per input transaction, in order; out_tuser carries the
// status, out_tdata the popped key and payload and the occupancy after the
// action.
// One transaction is in work at a time; in_tready is high only while the
// controller is idle. A push, a no-op or a pop on an empty queue is settled in
// the dispatch state; a pop reads the head slot there and takes it in the pop
// wait state. A cancel walks the queue from the head one slot per cycle
// through the single read port of the entry memory and, past the match,
// writes each later entry one place toward the head in the same walk. The
// result state loads the result into the output register, which raises
// out_tvalid; in_tready returns the cycle after the result is loaded.
// The output register parts the two sides: a new transaction is accepted
// while a result waits; the finished next result waits in the result hold
// until out_tready frees the register. Reset (rst_n low, synchronous) empties
// the queue and drops any pending result; only live slots are ever read.
module fifo_queue_with_cancel_by_key (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // [36:0] student_id, [68:37] entry_payload, [71:69] zero
  input  logic [qfk_pkg::IN_DATA_W-1:0]        in_tdata,
  // [1:0] action
  input  logic [qfk_pkg::ACT_W-1:0]            in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // [36:0] popped_id, [68:37] popped_payload, [75:69] occupancy, [79:76] zero
  output logic [qfk_pkg::OUT_DATA_W-1:0]       out_tdata,
  // [1:0] status
  output logic [qfk_pkg::ST_W-1:0]             out_tuser
);
  import qfk_pkg::*;

  localparam int OUT_PAD_W = OUT_DATA_W - (ID_W + PAY_W + OCC_W);

  qfk_cmd_t         cmd;
  qfk_sts_t         sts;
  logic [ID_W-1:0]  out_id;
  logic [PAY_W-1:0] out_pay;
  logic [OCC_W-1:0] out_occ;

  // Sequence each transaction
  qfk_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // Hold entries, pointers and the result
  qfk_dpath u_dpath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_act     (in_tuser),
    .in_key     (in_tdata[ID_W-1:0]),
    .in_pay     (in_tdata[ID_W+PAY_W-1:ID_W]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_status (out_tuser),
    .out_id     (out_id),
    .out_pay    (out_pay),
    .out_occ    (out_occ)
  );

  assign out_tdata = {{OUT_PAD_W{1'b0}}, out_occ, out_pay, out_id};

  // One transaction in work: no accept right after an accept
  a_single_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input accepted while a transaction is in work");

  // Never push into a full queue
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |-> !sts.full)
    else $error("push issued on a full queue");

  // A full report comes with a full occupancy
  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_FULL) |-> (out_occ == OCC_W'(DEPTH)))
    else $error("full status with occupancy below depth");

  // An empty report comes with zero occupancy and cleared data
  a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser == ST_EMPTY) |->
      (out_occ == '0) && (out_id == '0) && (out_pay == '0))
    else $error("empty status with entries or data");

endmodule
